[design/drd_pkg.sv]
// Shared widths, register indexes and types of the distance ridge detector.
`default_nettype none

package drd_pkg;

   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 12;
   localparam int DIST_W     = 16;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 12;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MIN_DISTANCE = 2'd2;
   localparam logic [1:0] REG_TOLERANCE    = 2'd3;

   localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd1024;
   localparam logic [HEIGHT_W-1:0] MIN_SIDE         = 12'd3;

   typedef struct packed {
      logic [WIDTH_W-1:0]  frame_width;
      logic [HEIGHT_W-1:0] frame_height;
   } geom_type;

   typedef struct packed {
      logic [COL_W-1:0] center_col;
      logic [ROW_W-1:0] center_row;
      logic             emit;
      logic             last;
   } pos_type;

endpackage

`default_nettype wire

[design/drd_linebuf.sv]
// Two line buffers packed into one synchronous memory, with same-entry forwarding.
`default_nettype none

module drd_linebuf #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_q_ff;
   logic [DW-1:0] fwd_data_ff;
   logic          fwd_ff;
   logic          fwd_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // A write to the entry being read in the same cycle wins over the stale array data.
   always_comb begin
      fwd_in = fwd_ff;
      if (rd_en) begin
         fwd_in = wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

`default_nettype wire

[design/drd_scan.sv]
// Raster position counters: line buffer address, centre coordinates and frame end.
`default_nettype none

module drd_scan #(
   parameter int MAX_WIDTH = 1024,
   parameter int CW        = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  drd_pkg::geom_type geom,
   input  logic              advance,
   output logic [CW-1:0]     addr,
   output drd_pkg::pos_type  pos
);
   import drd_pkg::*;

   localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

   logic [CW-1:0]       col_ff;
   logic [CW-1:0]       col_in;
   logic [ROW_W-1:0]    row_ff;
   logic [ROW_W-1:0]    row_in;
   logic [EW-1:0]       fw;
   logic [EW-1:0]       w_eff;
   logic [EW-1:0]       x_eff;
   logic [EW-1:0]       x_next;
   logic [HEIGHT_W-1:0] h_eff;
   logic [ROW_W:0]      y_next;
   logic                wrap;

   always_comb begin
      fw = EW'(geom.frame_width);
      if (fw < EW'(3)) begin
         w_eff = EW'(3);
      end else if (fw > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = fw;
      end
      h_eff = (geom.frame_height < MIN_SIDE) ? MIN_SIDE : geom.frame_height;

      // A column left beyond a narrowed width is pinned to the last column.
      x_eff  = (EW'(col_ff) >= w_eff) ? (w_eff - EW'(1)) : EW'(col_ff);
      x_next = x_eff + EW'(1);
      wrap   = (x_next >= w_eff);
      y_next = {1'b0, row_ff} + (ROW_W + 1)'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         col_in = wrap ? '0 : CW'(x_next);
         if (wrap) begin
            row_in = (y_next >= {1'b0, h_eff}) ? '0 : y_next[ROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign addr           = CW'(x_eff);
   assign pos.center_col = COL_W'(x_eff - EW'(1));
   assign pos.center_row = row_ff - ROW_W'(1);
   assign pos.emit       = (x_eff >= EW'(2)) && (row_ff >= ROW_W'(2));
   assign pos.last       = (x_eff == w_eff - EW'(1)) && (row_ff == h_eff - MIN_SIDE + 12'd2);

endmodule

`default_nettype wire

[design/drd_judge.sv]
// 3x3 window registers and the local maximum decision for the centre pixel.
`default_nettype none

module drd_judge #(
   parameter int SW = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift,
   input  logic [SW-1:0]              top,
   input  logic [SW-1:0]              mid,
   input  logic [SW-1:0]              sample,
   input  logic [drd_pkg::DIST_W-1:0] min_distance,
   input  logic [drd_pkg::DIST_W-1:0] tolerance,
   output logic                       ridge
);
   import drd_pkg::*;

   logic [SW-1:0]   window_ff [9];
   logic [SW-1:0]   center;
   logic [DIST_W:0] limit;
   logic            beaten;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= '0;
         end
      end else if (shift) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r*3]     <= window_ff[r*3 + 1];
            window_ff[r*3 + 1] <= window_ff[r*3 + 2];
         end
         window_ff[2] <= top;
         window_ff[5] <= mid;
         window_ff[8] <= sample;
      end
   end

   always_comb begin
      center = window_ff[4];
      limit  = (DIST_W + 1)'(center) + (DIST_W + 1)'(tolerance);
      beaten = 1'b0;
      for (int k = 0; k < 9; k++) begin
         if (k != 4 && (DIST_W + 1)'(window_ff[k]) > limit) begin
            beaten = 1'b1;
         end
      end
      ridge = (DIST_W'(center) > min_distance) && !beaten;
   end

endmodule

`default_nettype wire

[design/distance_ridge_detect_3x3.sv]
// Top level of the 3x3 ridge detector over a streamed distance map.
//
//   channel   direction  handshake             contents
//   req       in         req_valid/req_ready   one distance sample, raster order
//   rsp       out        rsp_valid/rsp_ready   centre column, row, ridge, frame end
//   csr       in/out     APB psel/penable      frame size, min distance, tolerance
//
// One sample is taken per cycle while the input is ready; a result passes through the
// first stage, the judged stage and the output register. The rate is set by the single
// line buffer memory, read when a sample is taken and written back when that sample
// leaves the first stage. Reset is synchronous and clears counters, window and valid
// flags; the line buffers need no clearing. A stalled result holds the output
// register, and the input stops only when the judged item behind it cannot move.
`default_nettype none

module distance_ridge_detect_3x3 #(
   parameter int MAX_WIDTH = 1024,
   parameter int DIST_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [drd_pkg::DIST_W-1:0]     req_distance,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [drd_pkg::COL_W-1:0]      rsp_center_col,
   output logic [drd_pkg::ROW_W-1:0]      rsp_center_row,
   output logic                           rsp_ridge,
   output logic                           rsp_frame_last,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [drd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [drd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [drd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import drd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int SW = (DIST_BITS < DIST_W) ? DIST_BITS : DIST_W;

   // Configuration registers
   logic [WIDTH_W-1:0]  frame_width_ff;
   logic [HEIGHT_W-1:0] frame_height_ff;
   logic [DIST_W-1:0]   min_distance_ff;
   logic [DIST_W-1:0]   tolerance_ff;
   logic                csr_write;
   logic [1:0]          csr_index;
   geom_type            geom;

   // Pipeline
   logic                accept;
   logic                out_free;
   logic                s1_go;
   logic                s2_go;
   logic                s2_hold;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [CW-1:0]       s1_addr_ff;
   logic [SW-1:0]       s1_d_ff;
   pos_type             s1_pos_ff;
   logic                s2_valid_ff;
   logic                s2_valid_in;
   pos_type             s2_pos_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [COL_W-1:0]    rsp_col_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic                rsp_ridge_ff;
   logic                rsp_last_ff;

   logic [CW-1:0]       scan_addr;
   pos_type             scan_pos;
   logic [2*SW-1:0]     lb_rd;
   logic                ridge;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         min_distance_ff <= '0;
         tolerance_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[WIDTH_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[HEIGHT_W-1:0];
            REG_MIN_DISTANCE: min_distance_ff <= csr_pwdata[DIST_W-1:0];
            REG_TOLERANCE:    tolerance_ff    <= csr_pwdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(frame_height_ff);
         REG_MIN_DISTANCE: csr_prdata = CSR_DATA_W'(min_distance_ff);
         REG_TOLERANCE:    csr_prdata = CSR_DATA_W'(tolerance_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign geom.frame_width  = frame_width_ff;
   assign geom.frame_height = frame_height_ff;

   // Stage control: the judged item waits only for the output register.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_hold   = s2_valid_ff && !out_free;
   assign s2_go     = s2_valid_ff && out_free;
   assign s1_go     = s1_valid_ff && !s2_hold;
   assign req_ready = !s1_valid_ff || !s2_hold;
   assign accept    = req_valid && req_ready;

   drd_scan #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .geom    (geom),
      .advance (accept),
      .addr    (scan_addr),
      .pos     (scan_pos)
   );

   drd_linebuf #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .DW    (2 * SW)
   ) u_linebuf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (scan_addr),
      .rd_data (lb_rd),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data ({lb_rd[SW-1:0], s1_d_ff})
   );

   drd_judge #(
      .SW (SW)
   ) u_judge (
      .clock        (clock),
      .reset        (reset),
      .shift        (s1_go),
      .top          (lb_rd[2*SW-1:SW]),
      .mid          (lb_rd[SW-1:0]),
      .sample       (s1_d_ff),
      .min_distance (min_distance_ff),
      .tolerance    (tolerance_ff),
      .ridge        (ridge)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (s1_go) begin
         s2_valid_in = s1_pos_ff.emit;
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s2_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= scan_addr;
         s1_d_ff    <= req_distance[SW-1:0];
         s1_pos_ff  <= scan_pos;
      end
      if (s1_go) begin
         s2_pos_ff <= s1_pos_ff;
      end
      if (s2_go) begin
         rsp_col_ff   <= s2_pos_ff.center_col;
         rsp_row_ff   <= s2_pos_ff.center_row;
         rsp_ridge_ff <= ridge;
         rsp_last_ff  <= s2_pos_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_center_col = rsp_col_ff;
   assign rsp_center_row = rsp_row_ff;
   assign rsp_ridge      = rsp_ridge_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

`default_nettype wire

[design/drd_check.sv]
// Port-level checks of the ridge detector, bound to its top level.
`default_nettype none

module drd_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [drd_pkg::COL_W-1:0]  rsp_center_col,
   input logic [drd_pkg::ROW_W-1:0]  rsp_center_row,
   input logic                       rsp_ridge,
   input logic                       rsp_frame_last
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_center_col)
         && $stable(rsp_center_row) && $stable(rsp_ridge) && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // Input back-pressure only comes from a stalled output.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output stall");

   // The next frame's first result is at least two rows away.
   a_frame_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_last |=> !rsp_valid)
      else $error("result directly after frame end");

endmodule

bind distance_ridge_detect_3x3 drd_check u_drd_check (.*);

`default_nettype wire
